>>> design/ihex_pkg.sv
// Shared types and constants for the Intel HEX record loader.
// No dependencies.
`default_nettype none

package ihex_pkg;

    localparam int unsigned MEM_BYTES_DEFAULT = 32'd1048576;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_SEGMENT   = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_LINEAR    = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data;
        logic        in_range;
    } result_t;

endpackage

`default_nettype wire

>>> design/ihex_parser.sv
// Record parser: one character per cycle while accept is high, state update and result build.
// Depends on ihex_pkg.
`default_nettype none

module ihex_parser #(
    parameter int unsigned MEM_BYTES = ihex_pkg::MEM_BYTES_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      char_in,
    output ihex_pkg::result_t    result,
    output logic                 emit
);

    localparam logic [32:0] MemLimit = 33'(MEM_BYTES);

    localparam logic [3:0] PH_WAIT  = 4'd0;
    localparam logic [3:0] PH_CNT_H = 4'd1;
    localparam logic [3:0] PH_CNT_L = 4'd2;
    localparam logic [3:0] PH_OFF_0 = 4'd3;
    localparam logic [3:0] PH_OFF_1 = 4'd4;
    localparam logic [3:0] PH_OFF_2 = 4'd5;
    localparam logic [3:0] PH_OFF_3 = 4'd6;
    localparam logic [3:0] PH_TYP_H = 4'd7;
    localparam logic [3:0] PH_TYP_L = 4'd8;
    localparam logic [3:0] PH_DAT_H = 4'd9;
    localparam logic [3:0] PH_DAT_L = 4'd10;

    localparam logic [7:0] COLON = 8'h3a;

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] accum_reg, accum_next;
    logic [7:0]  index_reg, index_next;
    logic [19:0] seg_reg, seg_next;
    logic [15:0] lin_reg, lin_next;
    logic [31:0] base_reg, base_next;

    logic        is_hex;
    logic [3:0]  digit;
    logic        finish;
    logic [7:0]  byte_val;
    logic [31:0] addr;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            digit = char_in[3:0];
        end
        else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                 (char_in >= 8'h61 && char_in <= 8'h66))
        begin
            digit = 4'(char_in[3:0] + 4'd9);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign byte_val = {nibble_reg, digit};
    assign addr     = base_reg + {16'd0, offset_reg} + {24'd0, index_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        type_next   = type_reg;
        accum_next  = accum_reg;
        index_next  = index_reg;
        seg_next    = seg_reg;
        lin_next    = lin_reg;
        finish      = 1'b0;
        emit        = 1'b0;
        result      = '0;

        if (accept)
        begin
            if (phase_reg != PH_WAIT && !is_hex)
            begin
                emit        = 1'b1;
                result.kind = ihex_pkg::KIND_ERROR;
                phase_next  = PH_WAIT;
            end
            else if (phase_reg != PH_WAIT)
            begin
                unique case (phase_reg) inside
                    PH_CNT_H, PH_TYP_H, PH_DAT_H:
                    begin
                        nibble_next = digit;
                        phase_next  = 4'(phase_reg + 4'd1);
                    end
                    PH_CNT_L:
                    begin
                        count_next = byte_val;
                        phase_next = PH_OFF_0;
                    end
                    PH_OFF_0, PH_OFF_1, PH_OFF_2, PH_OFF_3:
                    begin
                        offset_next = {offset_reg[11:0], digit};
                        phase_next  = 4'(phase_reg + 4'd1);
                    end
                    PH_TYP_L:
                    begin
                        type_next = byte_val;
                        if (count_reg == 8'd0)
                            finish = 1'b1;
                        else
                            phase_next = PH_DAT_H;
                    end
                    PH_DAT_L:
                    begin
                        accum_next = {accum_reg[23:0], byte_val};
                        if (type_reg == ihex_pkg::REC_DATA)
                        begin
                            emit            = 1'b1;
                            result.kind     = ihex_pkg::KIND_DATA;
                            result.address  = addr;
                            result.data     = byte_val;
                            result.in_range = ({1'b0, addr} < MemLimit);
                        end
                        index_next = 8'(index_reg + 8'd1);
                        if (index_next == count_reg)
                            finish = 1'b1;
                        else
                            phase_next = PH_DAT_H;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end

            if (finish)
            begin
                phase_next = PH_WAIT;
                case (type_next)
                    ihex_pkg::REC_SEGMENT:
                    begin
                        seg_next = {accum_next[15:0], 4'd0};
                    end
                    ihex_pkg::REC_START_SEG:
                    begin
                        emit           = 1'b1;
                        result.kind    = ihex_pkg::KIND_START;
                        result.address = {12'd0, accum_next[31:16], 4'd0}
                                       + {16'd0, accum_next[15:0]};
                    end
                    ihex_pkg::REC_LINEAR:
                    begin
                        lin_next = accum_next[15:0];
                        seg_next = 20'd0;
                    end
                    ihex_pkg::REC_START_LIN:
                    begin
                        emit           = 1'b1;
                        result.kind    = ihex_pkg::KIND_START;
                        result.address = accum_next;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // a colon opens a record, also one that breaks the current one
            if (char_in == COLON)
            begin
                phase_next  = PH_CNT_H;
                nibble_next = 4'd0;
                count_next  = 8'd0;
                offset_next = 16'd0;
                type_next   = 8'd0;
                accum_next  = 32'd0;
                index_next  = 8'd0;
            end
        end
    end

    assign base_next = {12'd0, seg_next} + {lin_next, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            nibble_reg <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            type_reg   <= '0;
            accum_reg  <= '0;
            index_reg  <= '0;
            seg_reg    <= '0;
            lin_reg    <= '0;
            base_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            type_reg   <= type_next;
            accum_reg  <= accum_next;
            index_reg  <= index_next;
            seg_reg    <= seg_next;
            lin_reg    <= lin_next;
            base_reg   <= base_next;
        end
    end

endmodule

`default_nettype wire

>>> design/ihex_out_queue.sv
// Two-entry result queue between the parser and the output channel.
// Depends on ihex_pkg.
`default_nettype none

module ihex_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  ihex_pkg::result_t      push_data,
    output logic                   full,
    output logic                   head_valid,
    input  wire logic              head_stall,
    output ihex_pkg::result_t      head
);

    logic [1:0]        count_reg, count_next;
    ihex_pkg::result_t slot0_reg, slot0_next;
    ihex_pkg::result_t slot1_reg, slot1_next;
    logic              pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;
    assign pop        = head_valid && !head_stall;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (pop && count_reg == 2'd1))
                slot0_next = push_data;
            else
                slot1_next = push_data;
        end
        count_next = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

>>> design/intel_hex_record_loader.sv
// Intel HEX record loader top level: parser plus output queue.
// Depends on ihex_pkg, ihex_parser, ihex_out_queue.
`default_nettype none

// Takes one character per clock and gives at most one result per character:
// a data byte write, a start address, or an error for an abandoned record.
// Each character is parsed in the cycle it is accepted; its result is registered into a
// two-entry queue and appears on the result channel once any result ahead of it is taken.
// char_stall rises only while both queue entries wait to be taken.

module intel_hex_record_loader #(
    parameter int unsigned MEM_BYTES = ihex_pkg::MEM_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_in,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [31:0]      address,
    output logic [7:0]       data,
    output logic             in_range
);

    ihex_pkg::result_t parsed;
    ihex_pkg::result_t head;
    logic              emit;
    logic              full;
    logic              accept;

    assign accept     = char_valid && !full;
    assign char_stall = full;

    ihex_parser #(
        .MEM_BYTES (MEM_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (char_in),
        .result  (parsed),
        .emit    (emit)
    );

    ihex_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (parsed),
        .full       (full),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head       (head)
    );

    assign kind     = head.kind;
    assign address  = head.address;
    assign data     = head.data;
    assign in_range = head.in_range;

endmodule

`default_nettype wire

>>> test/intel_hex_record_loader_test.sv
// Testbench for intel_hex_record_loader: feeds HEX text one character per beat and
// checks every result beat against an in-bench record parser.
// Depends on ihex_pkg and intel_hex_record_loader.
`timescale 1ns / 100ps

module intel_hex_record_loader_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [7:0] COLON = ":";

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_COUNT_HI,
        PH_COUNT_LO,
        PH_OFFSET,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_DATA_HI,
        PH_DATA_LO
    } parse_phase_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_in = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic        in_range;

    intel_hex_record_loader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_in      (char_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .in_range     (in_range)
    );

    // parser state mirrored in the bench
    parse_phase_t parse_phase = PH_IDLE;
    logic [3:0]   nibble_hold = '0;
    logic [7:0]   rec_count = '0;
    logic [15:0]  rec_offset = '0;
    logic [2:0]   offset_digits = '0;
    logic [7:0]   rec_type = '0;
    logic [31:0]  data_shift = '0;
    logic [7:0]   data_idx = '0;
    logic [19:0]  seg_base = '0;
    logic [15:0]  linear_upper = '0;

    ihex_pkg::result_t expected_loads[$];
    logic [7:0]        line_chars[$];
    int                mismatch_count = 0;
    int unsigned       cycle_count = 0;
    int                src_idle_pct = 0;
    int                sink_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 10)
            return "0" + n;
        if ($urandom_range(1))
            return "a" + n - 8'd10;
        return "A" + n - 8'd10;
    endfunction

    task automatic expect_load(input ihex_pkg::result_t r);
        expected_loads.insert(expected_loads.size(), r);
    endtask

    task automatic add_char(input logic [7:0] c);
        line_chars.insert(line_chars.size(), c);
    endtask

    task automatic open_record();
        parse_phase = PH_COUNT_HI;
        nibble_hold = '0;
        rec_count = '0;
        rec_offset = '0;
        offset_digits = '0;
        rec_type = '0;
        data_shift = '0;
        data_idx = '0;
    endtask

    task automatic close_record();
        logic [31:0] pc;
        case (rec_type)
            ihex_pkg::REC_SEGMENT:
                seg_base = {data_shift[15:0], 4'h0};
            ihex_pkg::REC_START_SEG:
            begin
                pc = {12'h0, data_shift[31:16], 4'h0} + {16'h0, data_shift[15:0]};
                expect_load(ihex_pkg::result_t'{ihex_pkg::KIND_START, pc, 8'd0, 1'b0});
            end
            ihex_pkg::REC_LINEAR:
            begin
                linear_upper = data_shift[15:0];
                seg_base = '0;
            end
            ihex_pkg::REC_START_LIN:
                expect_load(
                    ihex_pkg::result_t'{ihex_pkg::KIND_START, data_shift, 8'd0, 1'b0});
            default:
                ;
        endcase
        parse_phase = PH_IDLE;
    endtask

    task automatic predict_char(input logic [7:0] c);
        int          d;
        logic [7:0]  b;
        logic [31:0] addr;
        d = digit_value(c);
        if (parse_phase == PH_IDLE)
        begin
            if (c == COLON)
                open_record();
        end
        else if (d < 0)
        begin
            expect_load(ihex_pkg::result_t'{ihex_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b0});
            if (c == COLON)
                open_record();
            else
                parse_phase = PH_IDLE;
        end
        else
        begin
            case (parse_phase)
                PH_COUNT_HI:
                begin
                    nibble_hold = d[3:0];
                    parse_phase = PH_COUNT_LO;
                end
                PH_COUNT_LO:
                begin
                    rec_count = {nibble_hold, d[3:0]};
                    parse_phase = PH_OFFSET;
                end
                PH_OFFSET:
                begin
                    rec_offset = {rec_offset[11:0], d[3:0]};
                    offset_digits = offset_digits + 3'd1;
                    if (offset_digits == 4)
                        parse_phase = PH_TYPE_HI;
                end
                PH_TYPE_HI:
                begin
                    nibble_hold = d[3:0];
                    parse_phase = PH_TYPE_LO;
                end
                PH_TYPE_LO:
                begin
                    rec_type = {nibble_hold, d[3:0]};
                    if (rec_count == 0)
                        close_record();
                    else
                        parse_phase = PH_DATA_HI;
                end
                PH_DATA_HI:
                begin
                    nibble_hold = d[3:0];
                    parse_phase = PH_DATA_LO;
                end
                PH_DATA_LO:
                begin
                    b = {nibble_hold, d[3:0]};
                    data_shift = {data_shift[23:0], b};
                    if (rec_type == ihex_pkg::REC_DATA)
                    begin
                        addr = {12'h0, seg_base} + {linear_upper, 16'h0}
                             + {16'h0, rec_offset} + {24'h0, data_idx};
                        expect_load(ihex_pkg::result_t'{ihex_pkg::KIND_DATA, addr, b,
                                    addr < ihex_pkg::MEM_BYTES_DEFAULT});
                    end
                    data_idx = data_idx + 8'd1;
                    if (data_idx == rec_count)
                        close_record();
                    else
                        parse_phase = PH_DATA_HI;
                end
                default:
                    parse_phase = PH_IDLE;
            endcase
        end
    endtask

    // result side: check each accepted beat, then pick the next stall
    always @(posedge clk)
    begin
        ihex_pkg::result_t exp_load;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_loads.size() == 0)
            begin
                $error("unexpected result: kind %0d address %h data %h in_range %0d",
                       kind, address, data, in_range);
                mismatch_count++;
            end
            else
            begin
                exp_load = expected_loads.pop_front();
                if (kind !== exp_load.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_load.kind, kind);
                    mismatch_count++;
                end
                if (address !== exp_load.address)
                begin
                    $error("address: expected %h, got %h", exp_load.address, address);
                    mismatch_count++;
                end
                if (data !== exp_load.data)
                begin
                    $error("data: expected %h, got %h", exp_load.data, data);
                    mismatch_count++;
                end
                if (in_range !== exp_load.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", exp_load.in_range, in_range);
                    mismatch_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // called right after a rising edge; returns right after the edge that took the beat
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_in <= c;
        do
            @(posedge clk);
        while (char_stall);
        predict_char(c);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_chars.size(); i++)
            send_char(line_chars[i]);
        line_chars.delete();
    endtask

    task automatic push_hex_byte(input logic [7:0] b);
        add_char(hex_digit(b[7:4]));
        add_char(hex_digit(b[3:0]));
    endtask

    // up to four data bytes come from payload, newest byte lowest; longer records are random
    task automatic build_record(input logic [7:0] count, input logic [15:0] offset,
                                input logic [7:0] rtype, input logic [31:0] payload);
        int         i;
        logic [7:0] b;
        add_char(COLON);
        push_hex_byte(count);
        push_hex_byte(offset[15:8]);
        push_hex_byte(offset[7:0]);
        push_hex_byte(rtype);
        for (i = 0; i < count; i++)
        begin
            if (count <= 4)
                b = payload[8 * (count - 1 - i) +: 8];
            else
                b = 8'($urandom_range(255));
            push_hex_byte(b);
        end
    endtask

    task automatic truncate_line(input int keep);
        while (line_chars.size() > keep)
            void'(line_chars.pop_back());
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_loads.size() != 0);
    endtask

    task automatic random_stream(input int record_chars_wanted);
        int          sent;
        int          r;
        int          pick;
        logic [7:0]  count;
        logic [7:0]  rtype;
        logic [15:0] offset;
        logic [31:0] payload;
        logic [7:0]  bad;
        sent = 0;
        while (sent < record_chars_wanted)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 6))
                    add_char(8'($urandom_range(255)));
                sent += line_chars.size();
                send_line();
            end
            else
            begin
                pick = $urandom_range(99);
                count = (pick < 12) ? 8'd0 :
                        (pick < 75) ? 8'($urandom_range(1, 4)) :
                        (pick < 95) ? 8'($urandom_range(5, 16)) : 8'($urandom_range(17, 32));
                pick = $urandom_range(99);
                rtype = (pick < 45) ? ihex_pkg::REC_DATA :
                        (pick < 50) ? ihex_pkg::REC_EOF :
                        (pick < 58) ? ihex_pkg::REC_SEGMENT :
                        (pick < 66) ? ihex_pkg::REC_START_SEG :
                        (pick < 80) ? ihex_pkg::REC_LINEAR :
                        (pick < 90) ? ihex_pkg::REC_START_LIN : 8'($urandom_range(6, 255));
                offset = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                                  : 16'($urandom_range(16'hFFFF));
                payload = $urandom;
                if (rtype == ihex_pkg::REC_LINEAR)
                begin
                    pick = $urandom_range(9);
                    if (pick < 4)
                        payload[15:0] = 16'h0000;
                    else if (pick < 7)
                        payload[15:0] = 16'($urandom_range(16'h0010));
                    else if (pick < 8)
                        payload[15:0] = 16'hFFFF;
                end
                build_record(count, offset, rtype, payload);
                if (r < 22)
                begin
                    truncate_line($urandom_range(1, line_chars.size() - 1));
                    if ($urandom_range(9) < 4)
                        bad = COLON;
                    else
                        do
                            bad = 8'($urandom_range(255));
                        while (digit_value(bad) >= 0);
                    add_char(bad);
                    sent += line_chars.size();
                    send_line();
                end
                else
                begin
                    push_hex_byte(8'($urandom_range(255)));
                    pick = $urandom_range(9);
                    if (pick < 7)
                    begin
                        add_char(8'h0D);
                        add_char(8'h0A);
                    end
                    else if (pick < 9)
                        add_char(8'h0A);
                    sent += line_chars.size();
                    send_line();
                end
            end
        end
    endtask

    task automatic test_directed_records();
        src_idle_pct = 18;
        sink_idle_pct = 87;
        build_record(8'd2, 16'h0000, ihex_pkg::REC_LINEAR, 32'h0000FFFF);
        build_record(8'd1, 16'hFFFF, ihex_pkg::REC_DATA, 32'h000000AB);
        // second byte wraps the address past the top
        build_record(8'd2, 16'hFFFF, ihex_pkg::REC_DATA, 32'h0000CDEF);
        build_record(8'd2, 16'h0000, ihex_pkg::REC_SEGMENT, 32'h00001234);
        build_record(8'd1, 16'h0010, ihex_pkg::REC_DATA, 32'h0000005A);
        build_record(8'd0, 16'h0000, ihex_pkg::REC_LINEAR, 32'h00000000);
        build_record(8'd3, 16'h0000, ihex_pkg::REC_START_SEG, 32'h00123456);
        build_record(8'd4, 16'h0000, ihex_pkg::REC_START_LIN, 32'hFFFFFFFF);
        build_record(8'd0, 16'h0000, ihex_pkg::REC_EOF, 32'h00000000);
        build_record(8'd1, 16'h0000, 8'hFF, 32'h00000000);
        add_char(8'h00);
        add_char(8'hFF);
        send_line();
        // longest count, cut short by a non-hex character
        build_record(8'hFF, 16'h1234, ihex_pkg::REC_DATA, 32'h00000000);
        truncate_line(12);
        add_char(8'hFF);
        // colon inside a record restarts it
        add_char(COLON);
        add_char(COLON);
        add_char("0");
        add_char(8'h0A);
        send_line();
        drain_results();
    endtask

    task automatic test_stalled_sink();
        src_idle_pct = 18;
        sink_idle_pct = 87;
        random_stream(430);
        drain_results();
    endtask

    task automatic test_sparse_source();
        src_idle_pct = 87;
        sink_idle_pct = 18;
        random_stream(430);
        drain_results();
    endtask

    task automatic test_full_rate();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        random_stream(430);
        drain_results();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_records();
        test_stalled_sink();
        test_sparse_source();
        test_full_rate();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_loads.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
